FILE: design/vrs_pkg.sv
`default_nettype none

package vrs_pkg;

  // register file layout
  localparam int REG_W     = 48;
  localparam int FIELD_W   = 16;
  localparam int AXES      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int FIRST_W   = 17;
  localparam int EN_W      = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_POINT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INDEX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN    = 3'd6;

  // check enable bits
  localparam int EN_BOX      = 0;
  localparam int EN_RADIUS_X = 1;

  // offset clamp and square widths
  localparam int                  MAG_W        = 17;
  localparam logic [MAG_W-1:0]    OFFSET_CLAMP = 17'h1FFFF;
  localparam int                  SQ_W         = 2 * MAG_W;
  localparam int                  SUM_W        = SQ_W + 1;
  localparam int                  RSQ_W        = 2 * FIELD_W;

  // result count field
  localparam int COUNT_W = 17;

  // payload between the square stage and the result register
  typedef struct packed {
    logic                 idx_ok;
    logic                 box_ok;
    logic                 last;
    logic [SQ_W-1:0]      sq_x;
    logic [SQ_W-1:0]      sq_y;
    logic [SQ_W-1:0]      sq_z;
  } sq_stage_t;

endpackage

`default_nettype wire

FILE: design/vrs_in_if.sv
`default_nettype none

interface vrs_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_vertex, output ready);
endinterface

`default_nettype wire

FILE: design/vrs_out_if.sv
`default_nettype none

interface vrs_out_if;
  logic                         valid;
  logic                         ready;
  logic                         selected;
  logic [vrs_pkg::COUNT_W-1:0]  selected_count;
  logic                         set_done;

  modport source (output valid, selected, selected_count, set_done, input ready);
  modport sink   (input valid, selected, selected_count, set_done, output ready);
endinterface

`default_nettype wire

FILE: design/vrs_offset_sq.sv
`default_nettype none

module vrs_offset_sq #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0]        pos,
  input  logic signed [vrs_pkg::FIELD_W-1:0]  ref_val,
  output logic        [vrs_pkg::SQ_W-1:0]     sq
);
  import vrs_pkg::*;

  localparam int CW = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DW = CW + 1;
  localparam int AW = (DW > MAG_W) ? DW : MAG_W;

  logic signed [DW-1:0] diff;
  logic        [DW-1:0] diff_abs;
  logic        [AW-1:0] abs_ext;
  logic        [MAG_W-1:0] mag;

  // signed offset from the reference coordinate
  assign diff     = DW'(pos) - DW'(ref_val);
  assign diff_abs = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
  assign abs_ext  = AW'(diff_abs);

  // clamp large offsets, they exceed every radius anyway
  assign mag = (abs_ext > AW'(OFFSET_CLAMP)) ? OFFSET_CLAMP : abs_ext[MAG_W-1:0];

  assign sq = SQ_W'(mag) * SQ_W'(mag);

endmodule

`default_nettype wire

FILE: design/vertex_region_select_core.sv
// Vertex region select: one vertex beat in, one result beat out, at a sustained
// rate of one vertex per clock while the output side is ready. Each vertex goes
// through three registers (input, per-axis squared offsets, result); its result
// is presented from the result register and leaves when the output side is ready.
// Per-stage valid bits let the input keep flowing into empty stages while a
// result waits. A vertex is selected
// when its index within the set is at least first_index, it lies inside the box
// (when bit 0 of check_enables is set) and, for each axis enabled by bits 1..3,
// its squared distance from ref_point perpendicular to that axis lies between the
// squared radius_min and radius_max fields. selected_count counts selected
// vertices in the current set; index and count restart after a beat with
// last_vertex set. Registers are written through wr_en/wr_index/wr_data and must
// only change while no vertex is in flight.
`default_nettype none

module vertex_region_select_core #(
  parameter int MAX_VERTICES = 65536,
  parameter int COORD_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [vrs_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [vrs_pkg::REG_W-1:0]       wr_data,
  vrs_in_if.sink                          vtx,
  vrs_out_if.source                       res
);
  import vrs_pkg::*;

  localparam int VI_W  = $clog2(MAX_VERTICES);
  localparam int ST_W  = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W = (VI_W > FIRST_W) ? VI_W : FIRST_W;
  localparam int CW    = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  // configuration registers
  logic [REG_W-1:0]   box_min;
  logic [REG_W-1:0]   box_max;
  logic [REG_W-1:0]   ref_point;
  logic [REG_W-1:0]   radius_min;
  logic [REG_W-1:0]   radius_max;
  logic [FIRST_W-1:0] first_index;
  logic [EN_W-1:0]    check_enables;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min       <= '0;
      box_max       <= '0;
      ref_point     <= '0;
      radius_min    <= '0;
      radius_max    <= '1;
      first_index   <= '0;
      check_enables <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BOX_MIN:     box_min       <= wr_data;
        REG_BOX_MAX:     box_max       <= wr_data;
        REG_REF_POINT:   ref_point     <= wr_data;
        REG_RADIUS_MIN:  radius_min    <= wr_data;
        REG_RADIUS_MAX:  radius_max    <= wr_data;
        REG_FIRST_INDEX: first_index   <= wr_data[FIRST_W-1:0];
        REG_CHECK_EN:    check_enables <= wr_data[EN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // squared radius bounds, refreshed every cycle from the registers
  logic [RSQ_W-1:0] rmin_sq [AXES];
  logic [RSQ_W-1:0] rmax_sq [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_rsq
    always_ff @(posedge clk) begin
      rmin_sq[a] <= RSQ_W'(radius_min[FIELD_W*a +: FIELD_W]) *
                    RSQ_W'(radius_min[FIELD_W*a +: FIELD_W]);
      rmax_sq[a] <= RSQ_W'(radius_max[FIELD_W*a +: FIELD_W]) *
                    RSQ_W'(radius_max[FIELD_W*a +: FIELD_W]);
    end
  end

  // stage handshake
  logic v1, v2, vo;
  logic rdy_out, rdy2, rdy1;
  logic take1, adv12, adv2o;

  assign rdy_out   = !vo || res.ready;
  assign rdy2      = !v2 || rdy_out;
  assign rdy1      = !v1 || rdy2;
  assign vtx.ready = rdy1;
  assign take1     = vtx.valid && rdy1;
  assign adv12     = v1 && rdy2;
  assign adv2o     = v2 && rdy_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (take1)        v1 <= 1'b1;
      else if (adv12)   v1 <= 1'b0;
      if (adv12)        v2 <= 1'b1;
      else if (adv2o)   v2 <= 1'b0;
      if (adv2o)        vo <= 1'b1;
      else if (res.ready) vo <= 1'b0;
    end
  end

  // running vertex index, assigned as the beat is taken
  logic [VI_W-1:0] vertex_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_index <= '0;
    end else if (take1) begin
      if (vtx.last_vertex) begin
        vertex_index <= '0;
      end else if (vertex_index < VI_W'(MAX_VERTICES - 1)) begin
        vertex_index <= vertex_index + VI_W'(1);
      end
    end
  end

  // input register
  logic signed [COORD_BITS-1:0] p1 [AXES];
  logic                         last1;
  logic                         idx_ok1;

  always_ff @(posedge clk) begin
    if (take1) begin
      p1[0]   <= vtx.pos_x;
      p1[1]   <= vtx.pos_y;
      p1[2]   <= vtx.pos_z;
      last1   <= vtx.last_vertex;
      idx_ok1 <= CMP_W'(vertex_index) >= CMP_W'(first_index);
    end
  end

  // box test and per-axis squared offsets
  logic [AXES-1:0]  in_box;
  logic [SQ_W-1:0]  sq1 [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    logic signed [CW-1:0] pe, lo, hi;

    assign pe = CW'(p1[a]);
    assign lo = CW'($signed(box_min[FIELD_W*a +: FIELD_W]));
    assign hi = CW'($signed(box_max[FIELD_W*a +: FIELD_W]));
    assign in_box[a] = (pe >= lo) && (pe <= hi);

    vrs_offset_sq #(
      .COORD_BITS (COORD_BITS)
    ) u_offset_sq (
      .pos     (p1[a]),
      .ref_val ($signed(ref_point[FIELD_W*a +: FIELD_W])),
      .sq      (sq1[a])
    );
  end

  // square stage register
  sq_stage_t s2;

  always_ff @(posedge clk) begin
    if (adv12) begin
      s2.idx_ok <= idx_ok1;
      s2.box_ok <= &in_box;
      s2.last   <= last1;
      s2.sq_x   <= sq1[0];
      s2.sq_y   <= sq1[1];
      s2.sq_z   <= sq1[2];
    end
  end

  // radius bands: sum of squares over the two other axes
  logic [SUM_W-1:0] perp [AXES];
  logic [AXES-1:0]  band_ok;
  logic             ok;

  assign perp[0] = SUM_W'(s2.sq_y) + SUM_W'(s2.sq_z);
  assign perp[1] = SUM_W'(s2.sq_x) + SUM_W'(s2.sq_z);
  assign perp[2] = SUM_W'(s2.sq_x) + SUM_W'(s2.sq_y);

  for (genvar a = 0; a < AXES; a++) begin : g_band
    assign band_ok[a] = !check_enables[EN_RADIUS_X + a] ||
                        ((perp[a] >= SUM_W'(rmin_sq[a])) &&
                         (perp[a] <= SUM_W'(rmax_sq[a])));
  end

  assign ok = s2.idx_ok && (!check_enables[EN_BOX] || s2.box_ok) && (&band_ok);

  // selected count of the current set, saturating at the set limit
  logic [ST_W-1:0] select_total;
  logic [ST_W-1:0] total_after;

  assign total_after = (ok && (select_total < ST_W'(MAX_VERTICES))) ?
                       select_total + ST_W'(1) : select_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      select_total <= '0;
    end else if (adv2o) begin
      select_total <= s2.last ? '0 : total_after;
    end
  end

  // result register
  logic                sel_o;
  logic [COUNT_W-1:0]  count_o;
  logic                done_o;

  always_ff @(posedge clk) begin
    if (adv2o) begin
      sel_o   <= ok;
      count_o <= COUNT_W'(total_after);
      done_o  <= s2.last;
    end
  end

  assign res.valid          = vo;
  assign res.selected       = sel_o;
  assign res.selected_count = count_o;
  assign res.set_done       = done_o;

  // checks
  a_index_restart: assert property (@(posedge clk) disable iff (rst)
    (take1 && vtx.last_vertex) |=> (vertex_index == '0))
    else $error("vertex index did not restart after end of set");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    select_total <= ST_W'(MAX_VERTICES))
    else $error("selected total above set limit");

  a_no_checks_pass: assert property (@(posedge clk) disable iff (rst)
    (adv2o && s2.idx_ok && (check_enables == '0)) |=> (vo && sel_o))
    else $error("vertex rejected with no checks enabled");

endmodule

`default_nettype wire
